@@ hw/rtl/scwp_pkg.sv @@
package scwp_pkg;

  // Fixed field widths
  localparam int WORD_W = 27;
  localparam int DATA_W = 8;
  localparam int ADDR_W = 16;
  localparam int PTR_W  = 12;
  localparam int SLOT_W = 3;

  // Store depth in bytes; must be a power of two
  localparam int CONFIG_DEPTH = 4096;
  // Slots 1..SLOT_COUNT carry a window
  localparam int SLOT_COUNT   = 7;

  localparam int STORE_AW  = $clog2(CONFIG_DEPTH);
  localparam int PTR_EXT_W = (STORE_AW > PTR_W) ? STORE_AW : PTR_W;
  localparam int ROW_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  // Window layout: offsets EC..FF of the slot I/O page
  localparam int WIN_SIZE  = 20;
  localparam int WIN_IDX_W = $clog2(WIN_SIZE);

  localparam logic [7:0] WIN_BASE = 8'hEC;
  localparam logic [7:0] OFF_PLO  = 8'hEC;
  localparam logic [7:0] OFF_PHI  = 8'hED;
  localparam logic [7:0] OFF_RDP  = 8'hEE;
  localparam logic [7:0] OFF_WRP  = 8'hEF;
  localparam logic [7:0] OFF_USR  = 8'hF0;
  localparam logic [7:0] OFF_SIG  = 8'hF8;
  localparam logic [7:0] OFF_TYPE = 8'hFB;
  localparam logic [7:0] OFF_DIG  = 8'hFD;

  localparam logic [WIN_IDX_W-1:0] IDX_PLO  = WIN_IDX_W'(OFF_PLO - WIN_BASE);
  localparam logic [WIN_IDX_W-1:0] IDX_PHI  = WIN_IDX_W'(OFF_PHI - WIN_BASE);
  localparam logic [WIN_IDX_W-1:0] IDX_RDP  = WIN_IDX_W'(OFF_RDP - WIN_BASE);
  localparam logic [WIN_IDX_W-1:0] IDX_WRP  = WIN_IDX_W'(OFF_WRP - WIN_BASE);
  localparam logic [WIN_IDX_W-1:0] IDX_USR  = WIN_IDX_W'(OFF_USR - WIN_BASE);
  localparam logic [WIN_IDX_W-1:0] IDX_SIG  = WIN_IDX_W'(OFF_SIG - WIN_BASE);
  localparam logic [WIN_IDX_W-1:0] IDX_TYPE = WIN_IDX_W'(OFF_TYPE - WIN_BASE);
  localparam logic [WIN_IDX_W-1:0] IDX_DIG  = WIN_IDX_W'(OFF_DIG - WIN_BASE);

  localparam logic [7:0] SIGNATURE [8] = '{8'h56, 8'h32, 8'h41, 8'h78,
                                           8'h43, 8'h78, 8'h30, 8'h30};
  localparam logic [7:0] DIGIT_BASE = 8'h30;

  // Reset-vector fetch keys on bus word bits 8..26, both control bits set
  localparam logic [18:0] SEQ_KEY_FC = {1'b0, 16'hFFFC, 2'b11};
  localparam logic [18:0] SEQ_KEY_FD = {1'b0, 16'hFFFD, 2'b11};
  localparam logic [18:0] SEQ_KEY_62 = {1'b0, 16'hFA62, 2'b11};

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } ctl_state_t;

  typedef enum logic [3:0] {
    SEQ_IDLE = 4'b0001,
    SEQ_FC   = 4'b0010,
    SEQ_FD   = 4'b0100,
    SEQ_USB  = 4'b1000
  } seq_state_t;

  typedef logic [WIN_SIZE-1:0][DATA_W-1:0] win_row_t;

  // Row write request into the window mirror
  typedef struct packed {
    logic                en;
    logic [ROW_W-1:0]    row;
    logic [WIN_SIZE-1:0] be;
    win_row_t            data;
  } mir_wr_t;

  function automatic logic has_window(input logic [SLOT_W-1:0] slot);
    return (slot != '0) && (32'(slot) <= SLOT_COUNT);
  endfunction

  function automatic logic [ROW_W-1:0] row_of(input logic [SLOT_W-1:0] slot);
    logic [SLOT_W-1:0] dec;
    dec = slot - SLOT_W'(1);
    return has_window(slot) ? ROW_W'(dec) : '0;
  endfunction

  function automatic logic [STORE_AW-1:0] store_idx(input logic [PTR_W-1:0] ptr);
    logic [PTR_EXT_W-1:0] ext;
    ext = PTR_EXT_W'(ptr);
    return ext[STORE_AW-1:0];
  endfunction

  // Reset contents of one window byte
  function automatic logic [DATA_W-1:0] mir_default(input logic [WIN_IDX_W-1:0] k,
                                                    input logic [ROW_W-1:0]     row,
                                                    input logic [DATA_W-1:0]    type_id);
    logic [DATA_W-1:0]    res;
    logic [WIN_IDX_W-1:0] sidx;
    sidx = k - IDX_SIG;
    if (k < IDX_USR) begin
      res = '0;
    end else if (k < IDX_SIG) begin
      res = 8'hFF;
    end else if (k == IDX_TYPE) begin
      res = type_id;
    end else if (k == IDX_DIG) begin
      res = DIGIT_BASE + DATA_W'(row) + DATA_W'(1);
    end else begin
      res = SIGNATURE[sidx[2:0]];
    end
    return res;
  endfunction

endpackage

@@ hw/rtl/scwp_mirror.sv @@
module scwp_mirror (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   rd_en,
  input  logic [scwp_pkg::ROW_W-1:0]  rd_row,
  input  scwp_pkg::mir_wr_t      wr,
  input  logic                   type_load,
  input  logic [scwp_pkg::DATA_W-1:0] type_id,
  output scwp_pkg::win_row_t     rd_row_data
);
  import scwp_pkg::*;

  // One row per slot, one byte lane per window offset
  win_row_t                           mem [SLOT_COUNT];
  win_row_t                           rd_q_r;
  logic [ROW_W-1:0]                   rd_row_r;
  logic [SLOT_COUNT-1:0][WIN_SIZE-1:0] vld_r, vld_nxt;

  // Row memory: byte-lane write, registered read
  always_ff @(posedge clk) begin
    if (wr.en) begin
      for (int k = 0; k < WIN_SIZE; k++) begin
        if (wr.be[k]) begin
          mem[wr.row][k] <= wr.data[k];
        end
      end
    end
    if (rd_en) begin
      rd_q_r   <= mem[rd_row];
      rd_row_r <= rd_row;
    end
  end

  // Per-byte valid bits; a type load sends the type byte back to default
  always_comb begin
    vld_nxt = vld_r;
    if (wr.en) begin
      vld_nxt[wr.row] = vld_r[wr.row] | wr.be;
    end
    if (type_load) begin
      for (int r = 0; r < SLOT_COUNT; r++) begin
        vld_nxt[r][IDX_TYPE] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Bytes never written read as their reset contents
  always_comb begin
    for (int k = 0; k < WIN_SIZE; k++) begin
      rd_row_data[k] = vld_r[rd_row_r][k] ? rd_q_r[k]
                     : mir_default(WIN_IDX_W'(k), rd_row_r, type_id);
    end
  end

endmodule

@@ hw/rtl/slot_config_window_port_unit.sv @@
// Channel | Handshake            | Payload
// --------+----------------------+-----------------------------------------------
// in      | in_valid / in_ready  | in_bus_word, in_card_sel, in_dev_select,
//         |                      | in_io_select, in_is_read
// out     | out_valid / out_ready| out_read_data, out_read_valid, out_slot_number,
//         |                      | out_usb_rst_pulse, out_display_reset_pulse
// cfg     | cfg_wr_en            | cfg_wr_data (card type byte)
//
// For each item, the accept edge updates the pointer and the store and issues the store
// and window-mirror reads; the commit edge merges the mirror row, writes it back and
// loads the output register.
// After reset the config store is cleared one byte a cycle, with in_ready low until
// the sweep is done. Config writes are taken at any time.
// A result waiting in the output register stalls only the commit step of the
// following item.
module slot_config_window_port_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [scwp_pkg::WORD_W-1:0]  in_bus_word,
  input  logic                         in_card_sel,
  input  logic                         in_dev_select,
  input  logic                         in_io_select,
  input  logic                         in_is_read,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [scwp_pkg::DATA_W-1:0]  out_read_data,
  output logic                         out_read_valid,
  output logic [scwp_pkg::SLOT_W-1:0]  out_slot_number,
  output logic                         out_usb_rst_pulse,
  output logic                         out_display_reset_pulse,
  input  logic                         cfg_wr_en,
  input  logic [scwp_pkg::DATA_W-1:0]  cfg_wr_data
);
  import scwp_pkg::*;

  ctl_state_t              state_r, state_nxt;
  seq_state_t              seq_r, seq_nxt;
  logic [STORE_AW-1:0]     clr_cnt_r;
  logic [PTR_W-1:0]        ptr_r, ptr_nxt;
  logic [SLOT_W-1:0]       slot_r, slot_nxt;
  logic [DATA_W-1:0]       type_id_r;

  // Item held between accept and commit
  logic                    it_rd_r;
  logic                    it_win_r;
  logic [7:0]              it_off_r;
  logic [DATA_W-1:0]       it_data_r;
  logic [ROW_W-1:0]        it_row_r;
  logic                    it_usb_r, it_disp_r;

  logic                    out_valid_r;
  logic [DATA_W-1:0]       out_rdata_r;
  logic                    out_rvalid_r;
  logic [SLOT_W-1:0]       out_slot_r;
  logic                    out_usb_r, out_disp_r;

  // Config store
  logic [DATA_W-1:0]       store [CONFIG_DEPTH];
  logic [DATA_W-1:0]       store_q_r;
  logic                    st_we;
  logic [STORE_AW-1:0]     st_waddr, st_raddr;
  logic [DATA_W-1:0]       st_wdata;

  // Accept-side decode
  logic                    accept, commit;
  logic [ADDR_W-1:0]       addr;
  logic [7:0]              off;
  logic [DATA_W-1:0]       data;
  logic                    io_acc;
  logic [SLOT_W-1:0]       slot_io;
  logic [18:0]             seq_key;
  logic                    usb_nxt, disp_nxt;

  // Commit-side merge
  win_row_t                mir_row;
  mir_wr_t                 mir_wr;
  logic [WIN_IDX_W-1:0]    win_idx;
  logic [DATA_W-1:0]       rdata;
  logic                    rvalid;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign commit   = (state_r == ST_EXEC) && (!out_valid_r || out_ready);

  assign addr    = in_bus_word[25:10];
  assign off     = addr[7:0];
  assign data    = in_bus_word[7:0];
  assign io_acc  = in_card_sel && !in_dev_select && in_io_select;
  assign slot_io = addr[10:8];
  assign seq_key = in_bus_word[26:8];

  // Pointer, slot and store-write decode for the item being accepted
  always_comb begin
    ptr_nxt  = ptr_r;
    slot_nxt = slot_r;
    st_we    = 1'b0;
    st_waddr = store_idx(ptr_r);
    st_wdata = data;
    if (accept && in_card_sel) begin
      if (in_dev_select) begin
        slot_nxt = addr[6:4];
      end else if (in_io_select) begin
        slot_nxt = slot_io;
        if (!in_is_read) begin
          if (off == OFF_PLO) begin
            ptr_nxt = {ptr_r[PTR_W-1:8], data};
          end else if (off == OFF_PHI) begin
            ptr_nxt = {data[3:0], ptr_r[7:0]};
          end else if (off == OFF_WRP) begin
            st_we   = 1'b1;
            ptr_nxt = ptr_r + PTR_W'(1);
          end
        end else if (off == OFF_RDP) begin
          ptr_nxt = ptr_r + PTR_W'(1);
        end
      end
    end
    // Clearing sweep owns the write port
    if (state_r == ST_CLEAR) begin
      st_we    = 1'b1;
      st_waddr = clr_cnt_r;
      st_wdata = '0;
    end
  end

  assign st_raddr = store_idx(ptr_nxt);

  always_ff @(posedge clk) begin
    if (st_we) begin
      store[st_waddr] <= st_wdata;
    end
    store_q_r <= store[st_raddr];
  end

  // Reset-vector fetch detector, advanced by non-card items only
  always_comb begin
    seq_nxt  = seq_r;
    usb_nxt  = 1'b0;
    disp_nxt = 1'b0;
    if (accept && !in_card_sel) begin
      case (seq_r)
        SEQ_IDLE: if (seq_key == SEQ_KEY_FC) seq_nxt = SEQ_FC;
        SEQ_FC:   seq_nxt = (seq_key == SEQ_KEY_FD) ? SEQ_FD : SEQ_IDLE;
        SEQ_FD: begin
          if (seq_key == SEQ_KEY_62) begin
            seq_nxt = SEQ_USB;
            usb_nxt = 1'b1;
          end else begin
            seq_nxt = SEQ_IDLE;
          end
        end
        SEQ_USB: begin
          seq_nxt  = SEQ_IDLE;
          disp_nxt = 1'b1;
        end
        default: seq_nxt = SEQ_IDLE;
      endcase
    end
  end

  // Control sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (clr_cnt_r == STORE_AW'(CONFIG_DEPTH - 1)) state_nxt = ST_IDLE;
      ST_IDLE:  if (accept) state_nxt = ST_EXEC;
      ST_EXEC:  if (commit) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      seq_r       <= SEQ_IDLE;
      clr_cnt_r   <= '0;
      ptr_r       <= '0;
      slot_r      <= '0;
      type_id_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      seq_r   <= seq_nxt;
      ptr_r   <= ptr_nxt;
      slot_r  <= slot_nxt;
      if (state_r == ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + STORE_AW'(1);
      end
      if (cfg_wr_en) begin
        type_id_r <= cfg_wr_data;
      end
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Item capture at accept
  always_ff @(posedge clk) begin
    if (accept) begin
      it_rd_r   <= in_is_read;
      it_win_r  <= io_acc && has_window(slot_io);
      it_off_r  <= off;
      it_data_r <= data;
      it_row_r  <= row_of(slot_io);
      it_usb_r  <= usb_nxt;
      it_disp_r <= disp_nxt;
    end
  end

  scwp_mirror u_mirror (
    .clk         (clk),
    .rst_n       (rst_n),
    .rd_en       (accept),
    .rd_row      (row_of(slot_io)),
    .wr          (mir_wr),
    .type_load   (cfg_wr_en),
    .type_id     (type_id_r),
    .rd_row_data (mir_row)
  );

  assign win_idx = WIN_IDX_W'(it_off_r - WIN_BASE);

  // Mirror read answer and row write-back
  always_comb begin
    rdata       = '0;
    rvalid      = 1'b0;
    mir_wr.en   = 1'b0;
    mir_wr.row  = it_row_r;
    mir_wr.be   = '0;
    mir_wr.data = mir_row;
    if (it_win_r && it_off_r >= WIN_BASE) begin
      if (it_rd_r) begin
        rdata  = mir_row[win_idx];
        rvalid = 1'b1;
        if (it_off_r == OFF_RDP) begin
          mir_wr.be[IDX_PLO]   = 1'b1;
          mir_wr.be[IDX_PHI]   = 1'b1;
          mir_wr.be[IDX_RDP]   = 1'b1;
          mir_wr.be[IDX_WRP]   = 1'b1;
          mir_wr.data[IDX_PLO] = ptr_r[7:0];
          mir_wr.data[IDX_PHI] = DATA_W'(ptr_r[PTR_W-1:8]);
          mir_wr.data[IDX_RDP] = store_q_r;
          mir_wr.data[IDX_WRP] = store_q_r;
        end
      end else if (it_off_r == OFF_PLO || it_off_r == OFF_PHI
                   || it_off_r == OFF_WRP) begin
        mir_wr.be[IDX_RDP]   = 1'b1;
        mir_wr.be[IDX_WRP]   = 1'b1;
        mir_wr.data[IDX_RDP] = store_q_r;
        mir_wr.data[IDX_WRP] = store_q_r;
        if (it_off_r == OFF_PLO) begin
          mir_wr.be[IDX_PLO]   = 1'b1;
          mir_wr.data[IDX_PLO] = it_data_r;
        end else if (it_off_r == OFF_PHI) begin
          mir_wr.be[IDX_PHI]   = 1'b1;
          mir_wr.data[IDX_PHI] = {4'b0, it_data_r[3:0]};
        end
      end else if (it_off_r >= OFF_USR) begin
        mir_wr.be[win_idx]   = 1'b1;
        mir_wr.data[win_idx] = it_data_r;
      end
    end
    mir_wr.en = commit && (mir_wr.be != '0);
  end

  // Output register
  always_ff @(posedge clk) begin
    if (commit) begin
      out_rdata_r  <= rdata;
      out_rvalid_r <= rvalid;
      out_slot_r   <= slot_r;
      out_usb_r    <= it_usb_r;
      out_disp_r   <= it_disp_r;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_read_data           = out_rdata_r;
  assign out_read_valid          = out_rvalid_r;
  assign out_slot_number         = out_slot_r;
  assign out_usb_rst_pulse       = out_usb_r;
  assign out_display_reset_pulse = out_disp_r;

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import scwp_pkg::*;

  localparam int WATCHDOG_LIMIT   = 20000;
  localparam int LONG_HOLD_AFTER  = 400;
  localparam int LONG_HOLD_CYCLES = 80;

  // Window offsets, fetch keys and reset contents, kept apart from the RTL copies
  localparam logic [7:0]  W_FIRST    = 8'hEC;
  localparam logic [7:0]  W_LAST     = 8'hFF;
  localparam logic [7:0]  W_PTR_LO   = 8'hEC;
  localparam logic [7:0]  W_PTR_HI   = 8'hED;
  localparam logic [7:0]  W_RD_INC   = 8'hEE;
  localparam logic [7:0]  W_WR_INC   = 8'hEF;
  localparam logic [7:0]  W_USER     = 8'hF0;
  localparam logic [7:0]  W_SIG      = 8'hF8;
  localparam logic [7:0]  W_TYPE     = 8'hFB;
  localparam logic [7:0]  W_DIGIT    = 8'hFD;
  localparam logic [1:0]  CTRL_FETCH = 2'b11;
  localparam logic [15:0] VEC_LO     = 16'hFFFC;
  localparam logic [15:0] VEC_HI     = 16'hFFFD;
  localparam logic [15:0] VEC_ENTRY  = 16'hFA62;
  localparam logic [7:0]  SIG_BYTES [8] = '{8'h56, 8'h32, 8'h41, 8'h78,
                                            8'h43, 8'h78, 8'h30, 8'h30};

  typedef struct packed {
    logic [7:0] read_data;
    logic       read_valid;
    logic [2:0] slot_number;
    logic       usb_rst;
    logic       display_reset;
  } window_result_t;

  typedef struct packed {
    logic [WORD_W-1:0] bus_word;
    logic              card_sel;
    logic              dev_select;
    logic              io_select;
    logic              is_read;
    logic              fixed;  // result typed into the row
    window_result_t    want;
  } bus_event_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [WORD_W-1:0] in_bus_word = '0;
  logic              in_card_sel = 1'b0;
  logic              in_dev_select = 1'b0;
  logic              in_io_select = 1'b0;
  logic              in_is_read = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [DATA_W-1:0] out_read_data;
  logic              out_read_valid;
  logic [SLOT_W-1:0] out_slot_number;
  logic              out_usb_rst_pulse;
  logic              out_display_reset_pulse;
  logic              cfg_wr_en = 1'b0;
  logic [DATA_W-1:0] cfg_wr_data = '0;

  // Shadow of the block state
  logic [7:0]  store_img [CONFIG_DEPTH];
  logic [11:0] ptr_img;
  logic [7:0]  mirror_img [SLOT_COUNT+1][WIN_SIZE];
  seq_state_t  fetch_seq;
  logic [2:0]  slot_img;
  logic [7:0]  type_img;

  window_result_t window_expect_q [$];
  bus_event_t     directed_rows [$];

  int  events_sent    = 0;
  int  results_seen   = 0;
  int  reads_answered = 0;
  int  usb_seen       = 0;
  int  disp_seen      = 0;
  int  type_settings  = 0;
  int  mismatch_count = 0;
  int  quiet_cycles   = 0;
  int  send_idle_pct  = 0;
  int  recv_idle_pct  = 0;
  bit  long_hold_done = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  slot_config_window_port_unit DUT (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_ready                (in_ready),
    .in_bus_word             (in_bus_word),
    .in_card_sel             (in_card_sel),
    .in_dev_select           (in_dev_select),
    .in_io_select            (in_io_select),
    .in_is_read              (in_is_read),
    .out_valid               (out_valid),
    .out_ready               (out_ready),
    .out_read_data           (out_read_data),
    .out_read_valid          (out_read_valid),
    .out_slot_number         (out_slot_number),
    .out_usb_rst_pulse       (out_usb_rst_pulse),
    .out_display_reset_pulse (out_display_reset_pulse),
    .cfg_wr_en               (cfg_wr_en),
    .cfg_wr_data             (cfg_wr_data)
  );

  // ---------------------------------------------------------------- predictor

  function automatic bit windowed(logic [2:0] s);
    return (s != 3'd0) && (int'(s) <= SLOT_COUNT);
  endfunction

  // Writes to slots without a window or below EC are dropped
  function automatic void mirror_set(logic [2:0] s, logic [7:0] off, logic [7:0] v);
    if (windowed(s) && off >= W_FIRST) mirror_img[s][off - W_FIRST] = v;
  endfunction

  function automatic void mirror_follow_ptr(logic [2:0] s);
    mirror_set(s, W_RD_INC, store_img[int'(ptr_img) % CONFIG_DEPTH]);
    mirror_set(s, W_WR_INC, store_img[int'(ptr_img) % CONFIG_DEPTH]);
  endfunction

  function automatic void load_card_type(logic [7:0] v);
    type_img = v;
    for (int s = 1; s <= SLOT_COUNT; s++) mirror_set(3'(s), W_TYPE, v);
  endfunction

  function automatic void reset_window_model();
    for (int i = 0; i < CONFIG_DEPTH; i++) store_img[i] = '0;
    for (int s = 0; s <= SLOT_COUNT; s++) begin
      for (int k = 0; k < WIN_SIZE; k++) mirror_img[s][k] = '0;
    end
    for (int s = 1; s <= SLOT_COUNT; s++) begin
      for (int k = 0; k < 8; k++) begin
        mirror_set(3'(s), 8'(W_USER + k), 8'hFF);
        mirror_set(3'(s), 8'(W_SIG + k), SIG_BYTES[k]);
      end
      mirror_set(3'(s), W_DIGIT, 8'(8'h30 + s));
    end
    ptr_img   = '0;
    fetch_seq = SEQ_IDLE;
    slot_img  = '0;
    load_card_type(8'h00);
  endfunction

  function automatic window_result_t apply_bus_event(bus_event_t ev);
    window_result_t r;
    logic [15:0]    addr;
    logic [7:0]     data;
    logic [7:0]     off;
    logic [2:0]     s;
    logic [18:0]    key;
    r    = '0;
    addr = ev.bus_word[25:10];
    data = ev.bus_word[7:0];
    off  = addr[7:0];
    s    = addr[10:8];
    key  = ev.bus_word[26:8];
    if (ev.card_sel) begin
      if (ev.dev_select) begin
        slot_img = addr[6:4];
      end else if (ev.io_select) begin
        slot_img = s;
        // answer comes from the mirror as it stood before this item
        if (ev.is_read && off >= W_FIRST && windowed(s)) begin
          r.read_data  = mirror_img[s][off - W_FIRST];
          r.read_valid = 1'b1;
        end
        if (!ev.is_read) begin
          if (off == W_PTR_LO) begin
            mirror_set(s, W_PTR_LO, data);
            ptr_img[7:0] = data;
            mirror_follow_ptr(s);
          end else if (off == W_PTR_HI) begin
            mirror_set(s, W_PTR_HI, {4'h0, data[3:0]});
            ptr_img[11:8] = data[3:0];
            mirror_follow_ptr(s);
          end else if (off == W_WR_INC) begin
            store_img[int'(ptr_img) % CONFIG_DEPTH] = data;
            ptr_img = ptr_img + 12'd1;
            mirror_follow_ptr(s);
          end else if (off >= W_USER) begin
            mirror_set(s, off, data);
          end
        end else if (off == W_RD_INC) begin
          // pre-increment, then the pointer bytes follow
          ptr_img = ptr_img + 12'd1;
          mirror_follow_ptr(s);
          mirror_set(s, W_PTR_HI, {4'h0, ptr_img[11:8]});
          mirror_set(s, W_PTR_LO, ptr_img[7:0]);
        end
      end
    end else begin
      case (fetch_seq)
        SEQ_IDLE: begin
          if (key == {1'b0, VEC_LO, CTRL_FETCH}) fetch_seq = SEQ_FC;
        end
        SEQ_FC: begin
          fetch_seq = (key == {1'b0, VEC_HI, CTRL_FETCH}) ? SEQ_FD : SEQ_IDLE;
        end
        SEQ_FD: begin
          if (key == {1'b0, VEC_ENTRY, CTRL_FETCH}) begin
            fetch_seq = SEQ_USB;
            r.usb_rst = 1'b1;
          end else begin
            fetch_seq = SEQ_IDLE;
          end
        end
        default: begin
          r.display_reset = 1'b1;
          fetch_seq       = SEQ_IDLE;
        end
      endcase
    end
    r.slot_number = slot_img;
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic logic [WORD_W-1:0] pack_word(logic [15:0] a, logic [1:0] c,
                                                 logic [7:0] d);
    return {1'b0, a, c, d};
  endfunction

  function automatic logic [2:0] pick_slot();
    return ($urandom_range(0, 9) == 0) ? 3'd0 : 3'($urandom_range(1, SLOT_COUNT));
  endfunction

  // Window access with random upper address, control and top bits
  function automatic bus_event_t io_event(logic [2:0] s, logic [7:0] off, logic rd,
                                          logic [7:0] data);
    bus_event_t ev;
    ev           = '0;
    ev.bus_word  = {1'($urandom), 5'($urandom), s, off, 2'($urandom), data};
    ev.card_sel  = 1'b1;
    ev.io_select = 1'b1;
    ev.is_read   = rd;
    return ev;
  endfunction

  function automatic bus_event_t noise_event();
    bus_event_t ev;
    ev            = '0;
    ev.bus_word   = WORD_W'($urandom);
    ev.card_sel   = 1'($urandom);
    ev.dev_select = 1'($urandom);
    ev.io_select  = 1'($urandom);
    ev.is_read    = 1'($urandom);
    return ev;
  endfunction

  function automatic bus_event_t fetch_event(logic [15:0] a);
    bus_event_t ev;
    ev          = noise_event();
    ev.bus_word = pack_word(a, CTRL_FETCH, 8'($urandom));
    ev.card_sel = 1'b0;
    return ev;
  endfunction

  task automatic add_row(logic [WORD_W-1:0] w, logic cs, logic ds, logic ios, logic rd);
    bus_event_t ev;
    ev = '0;
    ev.bus_word   = w;
    ev.card_sel   = cs;
    ev.dev_select = ds;
    ev.io_select  = ios;
    ev.is_read    = rd;
    directed_rows.push_back(ev);
  endtask

  task automatic add_fixed(logic [WORD_W-1:0] w, logic cs, logic ds, logic ios, logic rd,
                           logic [7:0] rdata, logic rv, logic [2:0] sl, logic usb,
                           logic disp);
    bus_event_t ev;
    ev = '0;
    ev.bus_word   = w;
    ev.card_sel   = cs;
    ev.dev_select = ds;
    ev.io_select  = ios;
    ev.is_read    = rd;
    ev.fixed      = 1'b1;
    ev.want       = '{rdata, rv, sl, usb, disp};
    directed_rows.push_back(ev);
  endtask

  // Offer one item, hold it until taken, then maybe idle for a burst
  task automatic send_event(bus_event_t ev);
    window_result_t predicted;
    in_valid      <= 1'b1;
    in_bus_word   <= ev.bus_word;
    in_card_sel   <= ev.card_sel;
    in_dev_select <= ev.dev_select;
    in_io_select  <= ev.io_select;
    in_is_read    <= ev.is_read;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = apply_bus_event(ev);
    window_expect_q.push_back(ev.fixed ? ev.want : predicted);
    events_sent++;
    if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // Drop valid and let every outstanding result come back
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (window_expect_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_card_type(logic [7:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    load_card_type(v);
    type_settings++;
  endtask

  task automatic run_random(int count);
    int         stop_at;
    int         n;
    int         flip;
    int         broken;
    logic [2:0] s;
    logic [2:0] s2;
    logic [7:0] lo;
    logic [7:0] hi;
    bus_event_t ev;
    stop_at = events_sent + count;
    while (events_sent < stop_at) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          // pointer load, a burst of store writes, then read the bytes back
          s  = pick_slot();
          lo = 8'($urandom);
          hi = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 1));
          if ($urandom_range(0, 7) == 0) begin
            lo = 8'hFD;  // runs over the top of the pointer
            hi = 8'hFF;
          end
          n = $urandom_range(1, 6);
          send_event(io_event(s, W_PTR_LO, 1'b0, lo));
          send_event(io_event(s, W_PTR_HI, 1'b0, hi));
          repeat (n) send_event(io_event(s, W_WR_INC, 1'b0, 8'($urandom)));
          s2 = ($urandom_range(0, 3) == 0) ? pick_slot() : s;
          send_event(io_event(s2, W_PTR_LO, 1'b0, lo));
          send_event(io_event(s2, W_PTR_HI, 1'b0, hi));
          repeat (n) begin
            send_event(io_event(s2, ($urandom_range(0, 3) == 0) ? W_WR_INC : W_RD_INC,
                                1'b1, 8'($urandom)));
          end
        end
        3, 4, 5: begin
          // single window access, now and then outside the window
          send_event(io_event(pick_slot(),
                              ($urandom_range(0, 4) == 0) ? 8'($urandom)
                                : 8'($urandom_range(W_FIRST, W_LAST)),
                              1'($urandom), 8'($urandom)));
        end
        6, 7: begin
          // reset-vector fetches, sometimes with one step spoiled
          broken = $urandom_range(0, 3);
          n      = $urandom_range(0, 2);
          for (int k = 0; k < 3; k++) begin
            ev = fetch_event((k == 0) ? VEC_LO : (k == 1) ? VEC_HI : VEC_ENTRY);
            if (broken == 0 && n == k) begin
              flip = 8 + $urandom_range(0, 18);
              ev.bus_word[flip] = ~ev.bus_word[flip];
            end
            send_event(ev);
            // card traffic in between leaves the sequence alone
            if ($urandom_range(0, 5) == 0) begin
              send_event(io_event(pick_slot(), 8'($urandom_range(W_FIRST, W_LAST)),
                                  1'($urandom), 8'($urandom)));
            end
          end
          ev = noise_event();
          ev.card_sel = 1'b0;
          send_event(ev);
        end
        8: begin
          // device select, or card select with no space selected
          ev = noise_event();
          ev.card_sel  = 1'b1;
          ev.io_select = 1'b0;
          send_event(ev);
        end
        default: begin
          send_event(noise_event());
        end
      endcase
    end
  endtask

  // ---------------------------------------------------------------- result side

  // Random stalls, plus one long hold-off so the block backs up
  initial begin
    forever begin
      @(posedge clk);
      if (!long_hold_done && results_seen >= LONG_HOLD_AFTER) begin
        long_hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end else if (recv_idle_pct != 0 && $urandom_range(0, 99) < recv_idle_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Compare each result with the oldest expectation
  always @(posedge clk) begin : check_results
    window_result_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (out_read_valid) reads_answered++;
      if (out_usb_rst_pulse) usb_seen++;
      if (out_display_reset_pulse) disp_seen++;
      if (window_expect_q.size() == 0) begin
        $error("result with no item outstanding");
        mismatch_count++;
      end else begin
        want = window_expect_q.pop_front();
        if (out_read_data !== want.read_data) begin
          $error("read_data: expected %02h, got %02h", want.read_data, out_read_data);
          mismatch_count++;
        end
        if (out_read_valid !== want.read_valid) begin
          $error("read_valid: expected %0b, got %0b", want.read_valid, out_read_valid);
          mismatch_count++;
        end
        if (out_slot_number !== want.slot_number) begin
          $error("slot_number: expected %0d, got %0d", want.slot_number, out_slot_number);
          mismatch_count++;
        end
        if (out_usb_rst_pulse !== want.usb_rst) begin
          $error("usb_rst_pulse: expected %0b, got %0b", want.usb_rst,
                 out_usb_rst_pulse);
          mismatch_count++;
        end
        if (out_display_reset_pulse !== want.display_reset) begin
          $error("display_reset_pulse: expected %0b, got %0b", want.display_reset,
                 out_display_reset_pulse);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no handshake on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no handshake for %0d cycles", quiet_cycles);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    reset_window_model();

    // window bytes straight after reset, card type FF
    add_fixed(pack_word(16'hC1FB, 2'b00, 8'h00), 1'b1, 1'b0, 1'b1, 1'b1,
              8'hFF, 1'b1, 3'd1, 1'b0, 1'b0);
    add_fixed(pack_word(16'hC1FD, 2'b00, 8'h00), 1'b1, 1'b0, 1'b1, 1'b1,
              8'h31, 1'b1, 3'd1, 1'b0, 1'b0);
    add_fixed(pack_word(16'hC7F8, 2'b00, 8'h00), 1'b1, 1'b0, 1'b1, 1'b1,
              8'h56, 1'b1, 3'd7, 1'b0, 1'b0);
    add_fixed(pack_word(16'hC7FF, 2'b00, 8'h00), 1'b1, 1'b0, 1'b1, 1'b1,
              8'h30, 1'b1, 3'd7, 1'b0, 1'b0);
    // upper address bits take no part in the window decode
    add_fixed(pack_word(16'hFFF0, 2'b11, 8'hFF), 1'b1, 1'b0, 1'b1, 1'b1,
              8'hFF, 1'b1, 3'd7, 1'b0, 1'b0);
    add_fixed(pack_word(16'hC1EC, 2'b00, 8'h00), 1'b1, 1'b0, 1'b1, 1'b1,
              8'h00, 1'b1, 3'd1, 1'b0, 1'b0);
    // slot zero has no window
    add_fixed(pack_word(16'hC0EC, 2'b00, 8'h00), 1'b1, 1'b0, 1'b1, 1'b1,
              8'h00, 1'b0, 3'd0, 1'b0, 1'b0);
    // device select wins over I/O select
    add_fixed(pack_word(16'hC0F0, 2'b00, 8'h00), 1'b1, 1'b1, 1'b1, 1'b1,
              8'h00, 1'b0, 3'd7, 1'b0, 1'b0);
    // card select alone keeps the slot
    add_fixed(pack_word(16'hC2FB, 2'b00, 8'h00), 1'b1, 1'b0, 1'b0, 1'b1,
              8'h00, 1'b0, 3'd7, 1'b0, 1'b0);
    // reset-vector fetches, then the display pulse on the next bus item
    add_fixed(pack_word(VEC_LO, CTRL_FETCH, 8'h00), 1'b0, 1'b0, 1'b0, 1'b1,
              8'h00, 1'b0, 3'd7, 1'b0, 1'b0);
    add_fixed(pack_word(VEC_HI, CTRL_FETCH, 8'hFF), 1'b0, 1'b0, 1'b0, 1'b1,
              8'h00, 1'b0, 3'd7, 1'b0, 1'b0);
    add_fixed(pack_word(VEC_ENTRY, CTRL_FETCH, 8'h00), 1'b0, 1'b0, 1'b0, 1'b1,
              8'h00, 1'b0, 3'd7, 1'b1, 1'b0);
    add_fixed(pack_word(16'h0000, 2'b00, 8'h00), 1'b0, 1'b0, 1'b0, 1'b0,
              8'h00, 1'b0, 3'd7, 1'b0, 1'b1);
    add_fixed(27'h7FFFFFF, 1'b0, 1'b1, 1'b1, 1'b1,
              8'h00, 1'b0, 3'd7, 1'b0, 1'b0);
    // pointer, store and stale mirror traffic
    add_row(pack_word(16'hC2EC, 2'b00, 8'h34), 1'b1, 1'b0, 1'b1, 1'b0);
    add_row(pack_word(16'hC2ED, 2'b00, 8'hFF), 1'b1, 1'b0, 1'b1, 1'b0);
    add_row(pack_word(16'hC2EF, 2'b00, 8'hAB), 1'b1, 1'b0, 1'b1, 1'b0);
    add_row(pack_word(16'hC2EF, 2'b00, 8'h00), 1'b1, 1'b0, 1'b1, 1'b0);
    add_row(pack_word(16'hC2EC, 2'b00, 8'h34), 1'b1, 1'b0, 1'b1, 1'b0);
    add_row(pack_word(16'hC2EE, 2'b00, 8'h00), 1'b1, 1'b0, 1'b1, 1'b1);
    add_row(pack_word(16'hC2EF, 2'b00, 8'h00), 1'b1, 1'b0, 1'b1, 1'b1);
    add_row(pack_word(16'hC3F3, 2'b00, 8'h5A), 1'b1, 1'b0, 1'b1, 1'b0);
    add_row(pack_word(16'hC3F3, 2'b00, 8'h00), 1'b1, 1'b0, 1'b1, 1'b1);
    // store still written through a slot without a window
    add_row(pack_word(16'hC0EF, 2'b00, 8'h77), 1'b1, 1'b0, 1'b1, 1'b0);
    add_row(pack_word(16'hC5EE, 2'b00, 8'h99), 1'b1, 1'b0, 1'b1, 1'b0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    write_card_type(8'hFF);

    // directed rows
    send_idle_pct = 20;
    recv_idle_pct = 20;
    foreach (directed_rows[i]) send_event(directed_rows[i]);
    settle();

    // random traffic under several card type settings
    write_card_type(8'h00);
    send_idle_pct = 30;
    recv_idle_pct = 30;
    run_random(300);
    settle();

    write_card_type(8'($urandom_range(1, 254)));
    send_idle_pct = 10;
    recv_idle_pct = 10;
    run_random(300);
    settle();

    // last stretch back to back
    write_card_type(8'($urandom));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(225);
    settle();
    repeat (8) @(posedge clk);

    $display("Covered %0d bus items over %0d card type settings, %0d window reads answered",
             events_sent, type_settings, reads_answered);
    $display("Reset-vector sequence: %0d USB pulses, %0d display pulses",
             usb_seen, disp_seen);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
